/* sv/rgb_to_hsv_pixel_macros.svh */
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_macros
// assertion macros shared by the rgb to hsv pixel converter
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PIXEL_MACROS_SVH
`define RGB_TO_HSV_PIXEL_MACROS_SVH

`ifndef NO_ASSERTIONS
// property that must hold at every clock edge out of reset
`define RTH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rth assertion failed");
// property that must hold in the cycle after a trigger
`define RTH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rth assertion failed");
`else
`define RTH_ASSERT(lbl, prop)
`define RTH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* sv/rth_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rth_pkg
// types and constants of the rgb to hsv pixel converter
// ----------------------------------------------------------------------------
package rth_pkg;

  // channel and result widths
  localparam int unsigned PIX_W = 8;
  localparam int unsigned Q_W   = 8;

  // divider operand widths
  // hue: (510*num + 6d) / (12d), num <= 6d <= 1530
  localparam int unsigned HUE_NUM_W = 20;
  localparam int unsigned HUE_DEN_W = 12;
  // saturation: (510*d + mx) / (2*mx)
  localparam int unsigned SAT_NUM_W = 17;
  localparam int unsigned SAT_DEN_W = 9;

  // intermediate widths
  localparam int unsigned KD_W  = 11;
  localparam int unsigned NUM_W = 12;
  localparam int unsigned K_W   = 3;

  // twice the full scale, for half-up rounding
  localparam int unsigned SCALE2  = 510;
  localparam int unsigned SECTORS = 6;

  // sector bases picked by the minimum channel
  localparam logic [K_W-1:0] K_RED_MIN   = 3'd3;
  localparam logic [K_W-1:0] K_GREEN_MIN = 3'd5;
  localparam logic [K_W-1:0] K_BLUE_MIN  = 3'd1;

  // request moving down the divider chain
  typedef struct packed {
    logic [HUE_NUM_W-1:0] hue_rem;
    logic [HUE_DEN_W-1:0] hue_den;
    logic [SAT_NUM_W-1:0] sat_rem;
    logic [SAT_DEN_W-1:0] sat_den;
    logic [Q_W-1:0]       hue_quo;
    logic [Q_W-1:0]       sat_quo;
    logic [PIX_W-1:0]     brightness;
  } rth_work_t;

endpackage
`default_nettype wire

/* sv/rth_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rth_front
// first stage: extremes, sector offset and divider operands of a pixel
// ----------------------------------------------------------------------------
module rth_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rth_pkg::rth_work_t    out_work_o
);
  import rth_pkg::*;

  logic [PIX_W-1:0]        mx;
  logic [PIX_W-1:0]        mn;
  logic [PIX_W-1:0]        d;
  logic [K_W-1:0]          k;
  logic signed [PIX_W:0]   f;
  logic [KD_W-1:0]         kd;
  logic signed [NUM_W-1:0] num;
  logic [KD_W-1:0]         unum;
  rth_work_t               work_d;
  rth_work_t               work_q;
  logic                    valid_q;

  // largest and smallest channel
  always_comb begin
    mx = (red_i > green_i) ? red_i : green_i;
    mx = (mx > blue_i) ? mx : blue_i;
    mn = (red_i < green_i) ? red_i : green_i;
    mn = (mn < blue_i) ? mn : blue_i;
    d  = mx - mn;
  end

  // sector base and offset, red tested first on ties
  always_comb begin
    priority if (red_i == mn) begin
      k = K_RED_MIN;
      f = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i == mn) begin
      k = K_GREEN_MIN;
      f = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      k = K_BLUE_MIN;
      f = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
  end

  // hue numerator k*d - f, floored at zero
  always_comb begin
    kd   = KD_W'(k) * KD_W'(d);
    num  = $signed({1'b0, kd}) - $signed({{(NUM_W-PIX_W-1){f[PIX_W]}}, f});
    unum = num[NUM_W-1] ? '0 : num[KD_W-1:0];
  end

  // divider operands; a grey pixel divides zero by one
  always_comb begin
    work_d            = '0;
    work_d.brightness = mx;
    if (d == '0) begin
      work_d.hue_den = HUE_DEN_W'(1);
      work_d.sat_den = SAT_DEN_W'(1);
    end else begin
      work_d.hue_rem = HUE_NUM_W'(unum) * HUE_NUM_W'(SCALE2)
                     + HUE_NUM_W'(d) * HUE_NUM_W'(SECTORS);
      work_d.hue_den = HUE_DEN_W'(d) * HUE_DEN_W'(2 * SECTORS);
      work_d.sat_rem = SAT_NUM_W'(d) * SAT_NUM_W'(SCALE2) + SAT_NUM_W'(mx);
      work_d.sat_den = {mx, 1'b0};
    end
  end

  // stage handshake
  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // operand register
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      work_q <= work_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_work_o  = work_q;

endmodule
`default_nettype wire

/* sv/rth_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_hsv_pixel_macros.svh"
// ----------------------------------------------------------------------------
// rth_cell
// one restoring divider cell: settles one quotient bit of hue and saturation
// ----------------------------------------------------------------------------
module rth_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rth_pkg::rth_work_t    in_work_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rth_pkg::rth_work_t    out_work_o
);
  import rth_pkg::*;

  logic [HUE_NUM_W-1:0] hue_sub;
  logic [SAT_NUM_W-1:0] sat_sub;
  rth_work_t            work_d;
  rth_work_t            work_q;
  logic                 valid_q;

  // trial subtraction of the shifted divisors
  always_comb begin
    hue_sub = HUE_NUM_W'(in_work_i.hue_den) << BIT;
    sat_sub = SAT_NUM_W'(in_work_i.sat_den) << BIT;
    work_d  = in_work_i;
    if (in_work_i.hue_rem >= hue_sub) begin
      work_d.hue_rem      = in_work_i.hue_rem - hue_sub;
      work_d.hue_quo[BIT] = 1'b1;
    end
    if (in_work_i.sat_rem >= sat_sub) begin
      work_d.sat_rem      = in_work_i.sat_rem - sat_sub;
      work_d.sat_quo[BIT] = 1'b1;
    end
  end

  // stage handshake
  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // partial quotient register
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      work_q <= work_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_work_o  = work_q;

  // remainder stays below the divisor weight of this bit
  `RTH_ASSERT(a_hue_rem_bound, !valid_q || (work_q.hue_rem < (HUE_NUM_W'(work_q.hue_den) << BIT)))
  `RTH_ASSERT(a_sat_rem_bound, !valid_q || (work_q.sat_rem < (SAT_NUM_W'(work_q.sat_den) << BIT)))

endmodule
`default_nettype wire

/* sv/rgb_to_hsv_pixel.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_hsv_pixel_macros.svh"
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// 8-bit rgb pixel to 8-bit hsv converter
// ----------------------------------------------------------------------------
// Takes one pixel per clock while in_stall_o is low and gives one hsv result
// per pixel, in order. A front stage finds the extremes and divider operands,
// then a chain of eight divider cells settles one quotient bit each of hue and
// saturation, most significant bit first.
// Every stage holds its request while the next one stalls, so the chain keeps
// up to nine pixels in flight and stalls the input only when all are full.
// Hue and saturation are rounded half up; a grey pixel gives zero for both.
module rgb_to_hsv_pixel (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] hue_o,
  output logic [7:0] saturation_o,
  output logic [7:0] brightness_o
);
  import rth_pkg::*;

  logic      front_ready;
  logic      cell_valid [Q_W+1];
  logic      cell_ready [Q_W+1];
  rth_work_t cell_work  [Q_W+1];

  // extremes and operands
  rth_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (front_ready),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (cell_valid[0]),
    .out_ready_i (cell_ready[0]),
    .out_work_o  (cell_work[0])
  );

  // divider chain, one quotient bit per cell
  for (genvar i = 0; i < Q_W; i++) begin : g_cell
    rth_cell #(
      .BIT (Q_W - 1 - i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (cell_valid[i]),
      .in_ready_o  (cell_ready[i]),
      .in_work_i   (cell_work[i]),
      .out_valid_o (cell_valid[i+1]),
      .out_ready_i (cell_ready[i+1]),
      .out_work_o  (cell_work[i+1])
    );
  end

  // ports
  assign in_stall_o      = !front_ready;
  assign cell_ready[Q_W] = !out_stall_i;
  assign out_valid_o     = cell_valid[Q_W];
  assign hue_o           = cell_work[Q_W].hue_quo;
  assign saturation_o    = cell_work[Q_W].sat_quo;
  assign brightness_o    = cell_work[Q_W].brightness;

  // input stalls only when the chain is full and the output is stalled
  `RTH_ASSERT(a_stall_only_when_full, !in_stall_o || (out_valid_o && out_stall_i))
  // a black pixel never carries saturation
  `RTH_ASSERT(a_black_no_sat, !out_valid_o || brightness_o != '0 || saturation_o == '0)
  // a result taken with nothing behind it leaves the output empty
  `RTH_ASSERT_NEXT(a_drain, out_valid_o && !out_stall_i && !cell_valid[Q_W-1], !out_valid_o)

endmodule
`default_nettype wire
